/* hw/rtl/psa_pkg.sv */
// Shared types and constants for the posting score accumulator.
`default_nettype none

package psa_pkg;

  localparam int OP_W     = 2;
  localparam int REC_W    = 15;
  localparam int FREQ_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int WORDS_W  = 16;
  localparam int HITS_W   = 14;
  localparam int HREC_W   = 14;
  localparam int OUT_TOT_W = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 144;

  localparam logic [OP_W-1:0] OP_WORD  = 2'd0;
  localparam logic [OP_W-1:0] OP_POST  = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [WORDS_W-1:0] WORDS_MAX = 16'hFFFF;
  localparam logic [HITS_W-1:0]  HITS_MAX  = 14'h3FFF;

  // threshold is word_count / 4
  localparam int WORD_DIV_SHIFT = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POST,
    ST_SCAN,
    ST_END
  } state_t;

  typedef struct packed {
    logic [HREC_W-1:0]    hit_record;
    logic [OUT_TOT_W-1:0] freq_total;
    logic [COUNT_W-1:0]   match_count;
    logic [HITS_W-1:0]    drain_hits;
    logic [OUT_TOT_W-1:0] min_total;
    logic [OUT_TOT_W-1:0] max_total;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/psa_table.sv */
// Per-record count/total table: one write port, one registered read port.
`default_nettype none

module psa_table #(
  parameter int TABLE_DEPTH = 16384,
  parameter int DATA_W      = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]              rd_data,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]              wr_data
);

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psa_engine.sv */
// Sequencer: clearing sweep, posting read-modify-write and drain walk.
`default_nettype none

module psa_engine #(
  parameter int TABLE_DEPTH = 16384,
  parameter int TOTAL_WIDTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic        [psa_pkg::OP_W-1:0]              in_opcode,
  input  wire logic signed [psa_pkg::REC_W-1:0]             in_rec_no,
  input  wire logic        [psa_pkg::FREQ_W-1:0]            in_freq,
  output logic                                              rd_en,
  output logic             [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  input  wire logic        [psa_pkg::COUNT_W+TOTAL_WIDTH-1:0] rd_data,
  output logic                                              wr_en,
  output logic             [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
  output logic             [psa_pkg::COUNT_W+TOTAL_WIDTH-1:0] wr_data,
  input  wire logic                                         slot_free,
  output logic                                              res_push,
  output psa_pkg::res_t                                     res
);

  import psa_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = COUNT_W + TOTAL_WIDTH;
  localparam logic [PW-1:0] LAST_SLOT = PW'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] END_SLOT  = PW'(TABLE_DEPTH);
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

  state_t                 state_r, state_nxt;
  logic [PW-1:0]          scan_ptr_r, scan_ptr_nxt;
  logic [WORDS_W-1:0]     word_cnt_r, word_cnt_nxt;
  logic [HITS_W-1:0]      hits_r, hits_nxt;
  logic [TOTAL_WIDTH-1:0] min_r, min_nxt;
  logic [TOTAL_WIDTH-1:0] max_r, max_nxt;
  logic [AW-1:0]          post_addr_r, post_addr_nxt;
  logic [FREQ_W-1:0]      post_freq_r, post_freq_nxt;

  logic                   accept;
  logic                   rec_ok;
  logic [AW+REC_W-1:0]    rec_ext;
  logic [AW-1:0]          rec_addr;
  logic [PW-1:0]          scan_inc;
  logic                   scan_last;
  logic                   scan_done;
  logic [COUNT_W-1:0]     cnt_rd;
  logic [TOTAL_WIDTH-1:0] tot_rd;
  logic [COUNT_W-1:0]     cnt_sat;
  logic [TOTAL_WIDTH:0]   tot_sum;
  logic [TOTAL_WIDTH-1:0] tot_sat;
  logic                   hit;
  logic [HITS_W-1:0]      hits_inc;
  logic [TOTAL_WIDTH-1:0] min_upd, max_upd;
  logic [AW+HREC_W-1:0]   rec_out_ext;
  logic [TOTAL_WIDTH+OUT_TOT_W-1:0] tot_ext, min_ext, max_ext;
  logic [TOTAL_WIDTH+OUT_TOT_W-1:0] min_keep_ext, max_keep_ext;

  assign accept    = in_valid && in_ready;
  assign rec_ext   = {{AW{1'b0}}, in_rec_no};
  assign rec_addr  = rec_ext[AW-1:0];
  assign rec_ok    = (in_rec_no != '0) && !in_rec_no[REC_W-1]
                     && ({17'd0, in_rec_no} < 32'(TABLE_DEPTH));
  assign scan_inc  = scan_ptr_r + 1'b1;
  assign scan_last = (scan_ptr_r == LAST_SLOT);
  assign scan_done = (scan_ptr_r == END_SLOT);

  assign cnt_rd  = rd_data[DW-1:TOTAL_WIDTH];
  assign tot_rd  = rd_data[TOTAL_WIDTH-1:0];
  assign cnt_sat = (cnt_rd < COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
  assign tot_sum = (TOTAL_WIDTH+1)'(tot_rd) + (TOTAL_WIDTH+1)'(post_freq_r);
  assign tot_sat = tot_sum[TOTAL_WIDTH] ? TOTAL_MAX : tot_sum[TOTAL_WIDTH-1:0];

  assign hit      = (cnt_rd != '0) && (cnt_rd >= (word_cnt_r >> WORD_DIV_SHIFT));
  assign hits_inc = (hits_r < HITS_MAX) ? hits_r + 1'b1 : hits_r;
  assign max_upd  = ((max_r == '0) || (max_r < tot_rd)) ? tot_rd : max_r;
  assign min_upd  = ((min_r == '0) || (min_r > tot_rd)) ? tot_rd : min_r;

  // low bits of the kept values, zero-extended where narrower
  assign rec_out_ext  = {{HREC_W{1'b0}}, scan_ptr_r[AW-1:0]};
  assign tot_ext      = {{OUT_TOT_W{1'b0}}, tot_rd};
  assign min_ext      = {{OUT_TOT_W{1'b0}}, min_upd};
  assign max_ext      = {{OUT_TOT_W{1'b0}}, max_upd};
  assign min_keep_ext = {{OUT_TOT_W{1'b0}}, min_r};
  assign max_keep_ext = {{OUT_TOT_W{1'b0}}, max_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (scan_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (in_opcode == OP_POST) && rec_ok) state_nxt = ST_POST;
        else if (accept && (in_opcode == OP_DRAIN)) state_nxt = scan_done ? ST_END : ST_SCAN;
      end
      ST_POST: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else if (scan_last) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_ptr_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = scan_ptr_r[AW-1:0];
    wr_data       = '0;
    res_push      = 1'b0;
    res           = '0;
    scan_ptr_nxt  = scan_ptr_r;
    word_cnt_nxt  = word_cnt_r;
    hits_nxt      = hits_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    post_addr_nxt = post_addr_r;
    post_freq_nxt = post_freq_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        scan_ptr_nxt = scan_last ? '0 : scan_inc;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_opcode)
            OP_WORD: begin
              if (word_cnt_r < WORDS_MAX) word_cnt_nxt = word_cnt_r + 1'b1;
            end
            OP_POST: begin
              if (rec_ok) begin
                rd_en         = 1'b1;
                rd_addr       = rec_addr;
                post_addr_nxt = rec_addr;
                post_freq_nxt = in_freq;
              end
            end
            OP_DRAIN: begin
              // a walk already past the last slot goes straight to the end marker
              rd_en = !scan_done;
            end
            default: ;
          endcase
        end
      end
      ST_POST: begin
        wr_en   = 1'b1;
        wr_addr = post_addr_r;
        wr_data = {cnt_sat, tot_sat};
      end
      ST_SCAN: begin
        // a match waiting on a busy output holds the slot and the read data
        if (!hit || slot_free) begin
          wr_en        = 1'b1;
          scan_ptr_nxt = scan_inc;
          if (hit) begin
            res_push         = 1'b1;
            hits_nxt         = hits_inc;
            min_nxt          = min_upd;
            max_nxt          = max_upd;
            res.hit_record   = rec_out_ext[HREC_W-1:0];
            res.freq_total   = tot_ext[OUT_TOT_W-1:0];
            res.match_count  = cnt_rd;
            res.drain_hits   = hits_inc;
            res.min_total    = min_ext[OUT_TOT_W-1:0];
            res.max_total    = max_ext[OUT_TOT_W-1:0];
          end else if (!scan_last) begin
            rd_en   = 1'b1;
            rd_addr = scan_inc[AW-1:0];
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          res_push       = 1'b1;
          res.drain_hits = hits_r;
          res.min_total  = min_keep_ext[OUT_TOT_W-1:0];
          res.max_total  = max_keep_ext[OUT_TOT_W-1:0];
          res.last       = 1'b1;
          scan_ptr_nxt   = '0;
          word_cnt_nxt   = '0;
          hits_nxt       = '0;
          min_nxt        = '0;
          max_nxt        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      scan_ptr_r <= '0;
      word_cnt_r <= '0;
      hits_r     <= '0;
      min_r      <= '0;
      max_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      word_cnt_r <= word_cnt_nxt;
      hits_r     <= hits_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    post_addr_r <= post_addr_nxt;
    post_freq_r <= post_freq_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/posting_score_accumulator.sv */
// Top level: stream ports, result register and the table/sequencer pair.
//
// Input beats on in_* carry an opcode: count a query word, add a posting
// (record number and term frequency) into the per-record table, or drain
// the next match. Result beats on out_* carry one emitted match, or the end
// marker (out_tlast high) with hit count and min/max totals once the drain
// walk reaches the end of the table; the query state then starts over.
// A posting reads its slot and writes it back on the table memory. A drain
// walks the table slots in order; the walk reads and clears one slot each
// cycle on the single table read and write ports while no match waits on a
// busy output. A match shows on out_tvalid the cycle after its slot is
// walked.
// After reset a clearing pass writes zero into every slot with in_tready
// low. One result register sits on the output; the
// block takes the next input beat while a result waits there, and a drain
// that finds a match while that register is still full holds until
// out_tready frees it.
`default_nettype none

module posting_score_accumulator #(
  parameter int TABLE_DEPTH = 16384,
  parameter int TOTAL_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // opcode[1:0], rec_no[16:2], freq[32:17], zero fill [39:33]
  input  wire logic [psa_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // hit_record[13:0], freq_total[45:14], match_count[61:46],
  // drain_hits[75:62], min_total[107:76], max_total[139:108], zero [143:140]
  output logic      [psa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                    out_tlast
);

  import psa_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = COUNT_W + TOTAL_WIDTH;

  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [DW-1:0]           rd_data, wr_data;
  logic                    slot_free;
  logic                    res_push;
  res_t                    res;
  logic                    out_valid_r;
  res_t                    out_res_r;

  assign slot_free = !out_valid_r || out_tready;

  psa_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_opcode     (in_tdata[1:0]),
    .in_rec_no     (in_tdata[16:2]),
    .in_freq       (in_tdata[32:17]),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .slot_free     (slot_free),
    .res_push      (res_push),
    .res           (res)
  );

  psa_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_W      (DW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {4'd0,
                       out_res_r.max_total,
                       out_res_r.min_total,
                       out_res_r.drain_hits,
                       out_res_r.match_count,
                       out_res_r.freq_total,
                       out_res_r.hit_record};

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the posting score accumulator.
`timescale 1ns / 1ps

module tb;
  import psa_pkg::*;

  localparam int TBL_DEPTH = 16384;
  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int TAIL_CYCLES = 64;
  localparam int SQUEEZE_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [REC_W-1:0]  rec;
    logic [FREQ_W-1:0] freq;
    int                rep;
    bit                typed;
    res_t              want;
  } dir_step_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // predictor state
  logic [COUNT_W-1:0]   tally_cnt [TBL_DEPTH];
  logic [OUT_TOT_W-1:0] tally_tot [TBL_DEPTH];
  logic [WORDS_W-1:0]   query_words;
  int                   scan_ptr;
  logic [HITS_W-1:0]    hits_seen;
  logic [OUT_TOT_W-1:0] lo_total;
  logic [OUT_TOT_W-1:0] hi_total;
  bit                   query_closed;

  res_t pending_results[$];
  res_t seen_res;
  res_t want_res;
  dir_step_t dir_steps [20];

  int send_idle = 29;
  int recv_idle = 85;
  int stall_left = 0;
  int beats_sent = 0;
  int matches_checked = 0;
  int markers_checked = 0;
  int mismatches = 0;
  longint cycle_count = 0;

  posting_score_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_query();
    query_words = '0;
    scan_ptr    = 0;
    hits_seen   = '0;
    lo_total    = '0;
    hi_total    = '0;
  endfunction

  // Advance the score table by one beat; return 1 when the beat yields a result.
  function automatic bit score_model(input logic [OP_W-1:0] op, input logic [REC_W-1:0] rec,
                                     input logic [FREQ_W-1:0] freq, output res_t r);
    logic [OUT_TOT_W:0]   sum;
    logic [COUNT_W-1:0]   c;
    logic [OUT_TOT_W-1:0] t;
    int                   slot;
    r = '0;
    if (op == OP_WORD) begin
      if (query_words != WORDS_MAX) query_words++;
      return 1'b0;
    end
    if (op == OP_POST) begin
      // zero or negative record numbers are deleted postings
      if (rec == '0 || rec[REC_W-1]) return 1'b0;
      if (int'(rec) >= TBL_DEPTH) return 1'b0;
      if (tally_cnt[rec] != COUNT_MAX) tally_cnt[rec]++;
      sum = {1'b0, tally_tot[rec]} + freq;
      tally_tot[rec] = sum[OUT_TOT_W] ? '1 : sum[OUT_TOT_W-1:0];
      return 1'b0;
    end
    if (op == OP_DRAIN) begin
      while (scan_ptr < TBL_DEPTH) begin
        slot = scan_ptr;
        c = tally_cnt[slot];
        t = tally_tot[slot];
        tally_cnt[slot] = '0;
        tally_tot[slot] = '0;
        scan_ptr++;
        if (c != '0 && c >= (query_words >> WORD_DIV_SHIFT)) begin
          if (hits_seen != HITS_MAX) hits_seen++;
          if (hi_total == '0 || hi_total < t) hi_total = t;
          if (lo_total == '0 || lo_total > t) lo_total = t;
          r.hit_record  = slot[HREC_W-1:0];
          r.freq_total  = t;
          r.match_count = c;
          r.drain_hits  = hits_seen;
          r.min_total   = lo_total;
          r.max_total   = hi_total;
          r.last        = 1'b0;
          return 1'b1;
        end
      end
      r.drain_hits = hits_seen;
      r.min_total  = lo_total;
      r.max_total  = hi_total;
      r.last       = 1'b1;
      clear_query();
      query_closed = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                matches_checked + markers_checked, name, got, want));
  endtask

  // Result channel: compare every accepted beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res.hit_record  = out_tdata[13:0];
      seen_res.freq_total  = out_tdata[45:14];
      seen_res.match_count = out_tdata[61:46];
      seen_res.drain_hits  = out_tdata[75:62];
      seen_res.min_total   = out_tdata[107:76];
      seen_res.max_total   = out_tdata[139:108];
      seen_res.last        = out_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, record %0d last %0b",
                                  seen_res.hit_record, seen_res.last));
      end else begin
        want_res = pending_results.pop_front();
        check_field("hit_record", 32'(seen_res.hit_record), 32'(want_res.hit_record));
        check_field("freq_total", seen_res.freq_total, want_res.freq_total);
        check_field("match_count", 32'(seen_res.match_count), 32'(want_res.match_count));
        check_field("drain_hits", 32'(seen_res.drain_hits), 32'(want_res.drain_hits));
        check_field("min_total", seen_res.min_total, want_res.min_total);
        check_field("max_total", seen_res.max_total, want_res.max_total);
        check_field("last", 32'(seen_res.last), 32'(want_res.last));
        if (want_res.last) markers_checked++;
        else matches_checked++;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when stall_left is loaded.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle);
      end
    end
  end

  // Offer one beat; return at the rising edge that accepts it.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [REC_W-1:0] rec,
                           input logic [FREQ_W-1:0] freq, input bit typed,
                           input res_t typed_res);
    res_t r;
    bit   made;
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({freq, rec, op});
    do @(posedge clk); while (!in_tready);
    made = score_model(op, rec, freq, r);
    if (made) pending_results.push_back(typed ? typed_res : r);
    beats_sent++;
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    int roll;
    roll = $urandom_range(9, 0);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return FREQ_W'($urandom());
  endfunction

  task automatic drain_to_end();
    query_closed = 1'b0;
    while (!query_closed) send_beat(OP_DRAIN, REC_W'($urandom()), pick_freq(), 1'b0, '0);
  endtask

  // One query: words, postings on a small pool of records, a little noise, then drain.
  task automatic run_query();
    logic [REC_W-1:0] pool [8];
    int n_pool, n_words, n_posts, roll, i;
    n_pool = $urandom_range(8, 1);
    for (i = 0; i < n_pool; i++) begin
      roll = $urandom_range(9, 0);
      if (roll < 2) pool[i] = REC_W'($urandom_range(16, 1));
      else if (roll == 2) pool[i] = REC_W'(TBL_DEPTH - 1 - $urandom_range(15, 0));
      else pool[i] = REC_W'($urandom_range(TBL_DEPTH - 1, 1));
    end
    n_words = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
    for (i = 0; i < n_words; i++)
      send_beat(OP_WORD, REC_W'($urandom()), pick_freq(), 1'b0, '0);
    n_posts = $urandom_range(60, 5);
    for (i = 0; i < n_posts; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 5) begin
        send_beat(OP_WORD, REC_W'($urandom()), pick_freq(), 1'b0, '0);
      end else if (roll < 7) begin
        // drain in the middle of the query
        send_beat(OP_DRAIN, REC_W'($urandom()), pick_freq(), 1'b0, '0);
      end else if (roll < 11) begin
        send_beat(OP_UNUSED, REC_W'($urandom()), pick_freq(), 1'b0, '0);
      end else if (roll < 18) begin
        // any record number, deleted ones included
        send_beat(OP_POST, REC_W'($urandom()), pick_freq(), 1'b0, '0);
      end else begin
        send_beat(OP_POST, pool[$urandom_range(n_pool - 1, 0)], pick_freq(), 1'b0, '0);
      end
    end
    drain_to_end();
  endtask

  // Fill the output side: hold the receiver off while drains keep coming.
  task automatic squeeze_outputs();
    logic [REC_W-1:0] base;
    int i;
    base = REC_W'($urandom_range(16000, 1));
    for (i = 0; i < 16; i++)
      send_beat(OP_POST, base + REC_W'(i * 3), pick_freq(), 1'b0, '0);
    stall_left = SQUEEZE_CYCLES;
    drain_to_end();
  endtask

  initial begin
    int i, k;
    for (i = 0; i < TBL_DEPTH; i++) begin
      tally_cnt[i] = '0;
      tally_tot[i] = '0;
    end
    clear_query();

    dir_steps = '{
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b1, '{14'd0, 32'd0, 16'd0, 14'd0, 32'd0, 32'd0, 1'b1}},
      '{OP_UNUSED, 15'd16383, 16'hFFFF,  1, 1'b0, '0},
      '{OP_POST,   15'd0,     16'd5,     1, 1'b0, '0},
      '{OP_POST,   15'h7FFF,  16'd7,     1, 1'b0, '0},
      '{OP_POST,   15'h4000,  16'hFFFF,  1, 1'b0, '0},
      '{OP_POST,   15'd1,     16'd0,     1, 1'b0, '0},
      '{OP_POST,   15'd16383, 16'hFFFF,  1, 1'b0, '0},
      '{OP_POST,   15'd16383, 16'hFFFF,  1, 1'b0, '0},
      '{OP_POST,   15'd5,     16'd10,    1, 1'b0, '0},
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b1, '{14'd1, 32'd0, 16'd1, 14'd1, 32'd0, 32'd0, 1'b0}},
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b1, '{14'd5, 32'd10, 16'd1, 14'd2, 32'd10, 32'd10, 1'b0}},
      '{OP_POST,   15'd3,     16'd9,     1, 1'b0, '0},
      '{OP_WORD,   15'd0,     16'd0,     1, 1'b0, '0},
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b1,
        '{14'd16383, 32'd131070, 16'd2, 14'd3, 32'd10, 32'd131070, 1'b0}},
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b1,
        '{14'd0, 32'd0, 16'd0, 14'd3, 32'd10, 32'd131070, 1'b1}},
      '{OP_WORD,   15'h7FFF,  16'hFFFF,  8, 1'b0, '0},
      '{OP_POST,   15'd7,     16'd1,     1, 1'b0, '0},
      '{OP_POST,   15'd7,     16'd2,     1, 1'b0, '0},
      '{OP_DRAIN,  15'd0,     16'd0,     1, 1'b0, '0},
      '{OP_DRAIN,  15'h7FFF,  16'hFFFF,  1, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 20; i++)
      for (k = 0; k < dir_steps[i].rep; k++)
        send_beat(dir_steps[i].op, dir_steps[i].rec, dir_steps[i].freq,
                  dir_steps[i].typed, dir_steps[i].want);

    while (beats_sent < 570) run_query();
    send_idle = 85;
    recv_idle = 29;
    while (beats_sent < 1140) run_query();
    send_idle = 0;
    recv_idle = 0;
    squeeze_outputs();
    while (beats_sent < 1700) run_query();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input beats: %0d matches and %0d end-of-table markers checked",
             beats_sent, matches_checked, markers_checked);
    $display("deleted and unused beats, mid-drain mixing and a held-off receiver included");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
